// ===== sv/height_color_map_parser_unit_assert.svh =====
// Assertion macros shared by the height color map parser RTL.
`ifndef HEIGHT_COLOR_MAP_PARSER_UNIT_ASSERT_SVH
`define HEIGHT_COLOR_MAP_PARSER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside of reset.
`define HCMP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define HCMP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define HCMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hcmp_pkg.sv =====
// Package with the constants and types of the height color map parser.
package hcmp_pkg;

  localparam int MAX_COLS_DEFAULT = 1024;
  localparam int MAX_ROWS_DEFAULT = 1024;

  localparam int COLUMN_W = 10;
  localparam int ROW_W    = 10;
  localparam int HEIGHT_W = 31;
  localparam int COLOR_W  = 32;
  localparam int TEXT_W   = 8;
  localparam int OUT_TDATA_W = 88;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX    = 31'h7FFF_FFFF;
  localparam logic [COLOR_W-1:0]  DEFAULT_COLOR = 32'h00FF_FFFF;

  // Character codes.
  localparam logic [TEXT_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [TEXT_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [TEXT_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [TEXT_W-1:0] CH_NINE    = 8'h39;
  localparam logic [TEXT_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [TEXT_W-1:0] CH_UPPER_F = 8'h46;

  // Offsets that turn a character into a digit value.
  localparam logic [COLOR_W-1:0] DEC_OFFSET   = 32'd48;
  localparam logic [COLOR_W-1:0] UPPER_OFFSET = 32'd55;

  // Parser phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEIGHT = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_COLOR  = 2'd3;

  localparam logic [1:0] PREFIX_LEN = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [HEIGHT_W-1:0] height;
    logic [ROW_W-1:0]    row;
    logic [COLUMN_W-1:0] column;
    logic                final_point;
  } point_t;

endpackage

// ===== sv/height_color_map_parser_unit.sv =====
// Height color map text parser: turns map text bytes into points with column and row.
// Output: the byte that closes a field registers its point in the output buffer.
// Throughput: one text byte per cycle while the skid entry is free; the whole parse
// step for a byte sits between the parser state registers, and a two-entry output
// buffer keeps s_tready high while one point waits for m_tready.
// Reset: synchronous active-high rst clears the parser state and empties the buffer.
`include "height_color_map_parser_unit_assert.svh"

module height_color_map_parser_unit #(
  parameter int MAX_COLS = hcmp_pkg::MAX_COLS_DEFAULT,
  parameter int MAX_ROWS = hcmp_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hcmp_pkg::TEXT_W-1:0]     s_tdata,  // [7:0] text_byte
  input  logic                            s_tlast,  // end_of_text
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] column, [19:10] row, [50:20] height, [82:51] color, [87:83] zero
  output logic [hcmp_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast   // final_point
);
  import hcmp_pkg::*;

  // The column count saturates at MAX_COLS itself, so it needs room for that value.
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_COLS);
  localparam logic [CW-1:0] COL_LAST  = CW'(MAX_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(MAX_ROWS - 1);

  // Parser state.
  logic [1:0]          phase, phase_next;
  logic [HEIGHT_W-1:0] height_acc, height_acc_next;
  logic [COLOR_W-1:0]  color_acc, color_acc_next;
  logic [1:0]          prefix_left, prefix_left_next;
  logic                color_seen, color_seen_next;
  logic [CW-1:0]       col_count, col_count_next;
  logic [RW-1:0]       row_count, row_count_next;
  logic [CW-1:0]       line_width, line_width_next;
  logic                width_known, width_known_next;

  // Output buffer: a main register and a skid entry behind it.
  logic   out_valid, skid_valid;
  point_t out_point, skid_point;
  point_t new_point;
  logic   emit;

  logic accept;
  logic is_space, is_newline, is_sep, is_comma, is_digit, is_upper_hex;
  logic finish, newline_sep;
  logic [HEIGHT_W+3:0] height_mac;
  logic [COLOR_W-1:0]  hex_value;
  logic [CW-1:0]       col_sat;
  logic [31:0]         col_wide;
  logic [31:0]         row_wide;

  assign accept = s_tvalid && s_tready;

  assign is_space     = (s_tdata == CH_SPACE);
  assign is_newline   = (s_tdata == CH_NEWLINE);
  assign is_sep       = is_space || is_newline;
  assign is_comma     = (s_tdata == CH_COMMA);
  assign is_digit     = (s_tdata inside {[CH_ZERO:CH_NINE]});
  assign is_upper_hex = (s_tdata inside {[CH_UPPER_A:CH_UPPER_F]});

  // Any byte outside 'A'..'F' counts as its code minus 48, wrapping at 32 bits.
  assign hex_value = is_upper_hex ? (COLOR_W'(s_tdata) - UPPER_OFFSET)
                                  : (COLOR_W'(s_tdata) - DEC_OFFSET);

  always_comb begin
    phase_next       = phase;
    height_acc_next  = height_acc;
    color_acc_next   = color_acc;
    prefix_left_next = prefix_left;
    color_seen_next  = color_seen;
    col_count_next   = col_count;
    row_count_next   = row_count;
    line_width_next  = line_width;
    width_known_next = width_known;
    finish           = 1'b0;
    newline_sep      = 1'b0;
    emit             = 1'b0;
    height_mac       = '0;
    col_sat          = '0;
    col_wide         = '0;
    row_wide         = '0;
    new_point        = '0;

    // A non-separator byte between fields opens a new field.
    if (phase == PH_IDLE && !is_sep) begin
      phase_next       = PH_HEIGHT;
      height_acc_next  = '0;
      color_acc_next   = '0;
      color_seen_next  = 1'b0;
      prefix_left_next = '0;
    end

    case (phase_next)
      PH_IDLE: begin
        newline_sep = is_newline;
      end
      PH_HEIGHT: begin
        if (is_digit) begin
          // Saturate when ten times the height plus the digit passes the maximum.
          height_mac = (HEIGHT_W+4)'(height_acc_next) * (HEIGHT_W+4)'(10)
                       + (HEIGHT_W+4)'(s_tdata[3:0]);
          if (height_mac > (HEIGHT_W+4)'(HEIGHT_MAX)) begin
            height_acc_next = HEIGHT_MAX;
          end else begin
            height_acc_next = height_mac[HEIGHT_W-1:0];
          end
        end else if (is_comma) begin
          phase_next       = PH_PREFIX;
          prefix_left_next = PREFIX_LEN;
          color_seen_next  = 1'b1;
          color_acc_next   = '0;
        end else if (is_sep) begin
          finish      = 1'b1;
          newline_sep = is_newline;
        end
      end
      PH_PREFIX: begin
        // The two bytes after the comma are dropped, separators included.
        if (prefix_left_next != '0) begin
          prefix_left_next = prefix_left_next - 2'd1;
        end
        if (prefix_left_next == '0) begin
          phase_next = PH_COLOR;
        end
      end
      PH_COLOR: begin
        if (is_sep) begin
          finish      = 1'b1;
          newline_sep = is_newline;
        end else begin
          color_acc_next = {color_acc_next[COLOR_W-5:0], 4'h0} + hex_value;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (s_tlast && phase_next != PH_IDLE) begin
      finish = 1'b1;
    end

    if (finish) begin
      col_sat  = (col_count_next > COL_LAST) ? COL_LAST : col_count_next;
      col_wide = 32'(col_sat);
      row_wide = 32'(row_count_next);
      new_point.column      = col_wide[COLUMN_W-1:0];
      new_point.row         = row_wide[ROW_W-1:0];
      new_point.height      = height_acc_next;
      new_point.color       = color_seen_next ? color_acc_next : DEFAULT_COLOR;
      new_point.final_point = s_tlast;
      emit             = 1'b1;
      phase_next       = PH_IDLE;
      prefix_left_next = '0;
      if (col_count_next < COL_LIMIT) begin
        col_count_next = col_count_next + CW'(1);
      end
      // Wrap to the next row once a full line of the learned width is out.
      if (width_known_next && col_count_next >= line_width_next) begin
        col_count_next = '0;
        if (row_count_next < ROW_LAST) begin
          row_count_next = row_count_next + RW'(1);
        end
      end
    end

    // The first newline after at least one field fixes the line width.
    if (newline_sep && !width_known_next && col_count_next != '0) begin
      width_known_next = 1'b1;
      line_width_next  = col_count_next;
      col_count_next   = '0;
      if (row_count_next < ROW_LAST) begin
        row_count_next = row_count_next + RW'(1);
      end
    end

    // The last byte of the text leaves the parser as after reset.
    if (s_tlast) begin
      phase_next       = PH_IDLE;
      height_acc_next  = '0;
      color_acc_next   = '0;
      prefix_left_next = '0;
      color_seen_next  = 1'b0;
      col_count_next   = '0;
      row_count_next   = '0;
      line_width_next  = '0;
      width_known_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      height_acc  <= '0;
      color_acc   <= '0;
      prefix_left <= '0;
      color_seen  <= 1'b0;
      col_count   <= '0;
      row_count   <= '0;
      line_width  <= '0;
      width_known <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      height_acc  <= height_acc_next;
      color_acc   <= color_acc_next;
      prefix_left <= prefix_left_next;
      color_seen  <= color_seen_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      line_width  <= line_width_next;
      width_known <= width_known_next;
    end
  end

  // Input is taken whenever the skid entry is free, so one waiting point
  // never holds up the text stream.
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= accept && emit;
      end else if (m_tready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && emit;
        end
      end else if (accept && emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_point <= skid_valid ? skid_point : new_point;
    end
    if (out_valid && !m_tready && !skid_valid) begin
      skid_point <= new_point;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - COLOR_W - HEIGHT_W - ROW_W - COLUMN_W)'(0),
                     out_point.color, out_point.height, out_point.row,
                     out_point.column};
  assign m_tlast  = out_point.final_point;

  `HCMP_ASSERT_SAME(a_skid_behind_main, skid_valid, out_valid, "skid entry full while main empty")
  `HCMP_ASSERT_NEXT(a_text_end_clears, accept && s_tlast, phase == PH_IDLE && col_count == '0 && row_count == '0 && !width_known, "state not cleared after end of text")
  `HCMP_ASSERT_SAME(a_rows_need_width, row_count != '0, width_known, "row advanced before line width was learned")
  `HCMP_ASSERT_SAME(a_prefix_count, phase == PH_PREFIX, prefix_left != '0, "prefix phase with no bytes left to skip")

endmodule
